FILE: sv/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

   localparam int MAX_JOBS    = 16;
   localparam int IDX_W       = $clog2(MAX_JOBS);
   localparam int CNT_W       = $clog2(MAX_JOBS + 1);

   localparam int FUEL_W      = 10;
   localparam int LEVEL_W     = 2;
   localparam int ENTRY_W     = LEVEL_W + FUEL_W;
   localparam int JOB_INDEX_W = 4;
   localparam int TIME_W      = 14;
   localparam int SUM_W       = 18;

   localparam logic [TIME_W-1:0] CLOCK_MAX = {TIME_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one loaded job as it travels from the front end to the back end
   typedef struct packed {
      logic               keep;   // table had room when the item came in
      logic               last;
      logic [LEVEL_W-1:0] level;
      logic [FUEL_W-1:0]  fuel;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

`default_nettype wire

FILE: sv/nps_ram.sv
// ----------------------------------------------------------------------------
// nps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/nps_front.sv
// ----------------------------------------------------------------------------
// nps_front
// Accepts job items, marks those that overflow the job table and holds them
// in a short queue for the scheduling back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [nps_pkg::FUEL_W-1:0]   req_fuel_amount,
   input  wire logic [nps_pkg::LEVEL_W-1:0]  req_urgency_level,
   input  wire logic                         req_last_job,
   output nps_pkg::head_type                 head,
   input  wire logic                         pop
);

   nps_pkg::job_type              q_ff [nps_pkg::QUEUE_DEPTH];
   logic [nps_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [nps_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [nps_pkg::QPTR_W:0]      q_count_ff, q_count_in;
   logic [nps_pkg::CNT_W-1:0]     fcount_ff, fcount_in;
   logic                          accept;
   logic                          do_pop;
   logic                          keep;
   nps_pkg::job_type              new_job;

   assign busy   = (q_count_ff == (nps_pkg::QPTR_W+1)'(nps_pkg::QUEUE_DEPTH));
   assign accept = start && !busy;
   assign do_pop = pop && (q_count_ff != '0);
   assign keep   = (fcount_ff < nps_pkg::CNT_W'(nps_pkg::MAX_JOBS));

   always_comb begin
      new_job.keep  = keep;
      new_job.last  = req_last_job;
      new_job.level = req_urgency_level;
      new_job.fuel  = req_fuel_amount;
   end

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      q_count_in = q_count_ff;
      fcount_in  = fcount_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + nps_pkg::QPTR_W'(1);
         // track the batch size so that overflow jobs can be dropped
         if (req_last_job) begin
            fcount_in = '0;
         end else if (keep) begin
            fcount_in = fcount_ff + nps_pkg::CNT_W'(1);
         end
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + nps_pkg::QPTR_W'(1);
      end
      if (accept && !do_pop) begin
         q_count_in = q_count_ff + (nps_pkg::QPTR_W+1)'(1);
      end else if (!accept && do_pop) begin
         q_count_in = q_count_ff - (nps_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
         fcount_ff  <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
         fcount_ff  <= fcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end

   always_comb begin
      head.valid = (q_count_ff != '0);
      head.job   = q_ff[rd_ptr_ff];
   end

endmodule

`default_nettype wire

FILE: sv/nps_back.sv
// ----------------------------------------------------------------------------
// nps_back
// Loads jobs into the job table and, on the last job of a batch, serves them
// one at a time: a scan over the table picks the next job, then its times
// are worked out and sent as one result.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire nps_pkg::head_type                 head,
   output logic                                   pop,
   output logic                                   rsp_strobe,
   output logic [nps_pkg::JOB_INDEX_W-1:0]        rsp_job_index,
   output logic [nps_pkg::TIME_W-1:0]             rsp_completion_time,
   output logic [nps_pkg::TIME_W-1:0]             rsp_waiting_time,
   output logic [nps_pkg::TIME_W-1:0]             rsp_turnaround_time,
   output logic [nps_pkg::SUM_W-1:0]              rsp_total_waiting,
   output logic                                   rsp_last_result
);

   localparam int IDX_W  = nps_pkg::IDX_W;
   localparam int CNT_W  = nps_pkg::CNT_W;
   localparam int TIME_W = nps_pkg::TIME_W;
   localparam int SUM_W  = nps_pkg::SUM_W;
   localparam int FUEL_W = nps_pkg::FUEL_W;
   localparam int LVL_W  = nps_pkg::LEVEL_W;
   localparam int JIX_W  = nps_pkg::JOB_INDEX_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_PICK  = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;
   localparam logic [2:0] ST_TIMES = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [nps_pkg::MAX_JOBS-1:0] served_ff, served_in;
   logic [TIME_W-1:0]          clock_ff, clock_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           k_ff, k_in;
   logic [CNT_W-1:0]           scan_ff, scan_in;
   logic                       cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           pick_ff, pick_in;
   logic [LVL_W-1:0]           pick_lvl_ff, pick_lvl_in;
   logic                       first_found_ff, first_found_in;
   logic [IDX_W-1:0]           first_ff, first_in;
   logic [FUEL_W-1:0]          svc_ff, svc_in;
   logic [TIME_W-1:0]          done_ff, done_in;
   logic [TIME_W-1:0]          turn_ff, turn_in;
   logic [TIME_W-1:0]          wait_ff, wait_in;

   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic [JIX_W-1:0]           rsp_index_ff, rsp_index_in;
   logic [TIME_W-1:0]          rsp_done_ff, rsp_done_in;
   logic [TIME_W-1:0]          rsp_wait_ff, rsp_wait_in;
   logic [TIME_W-1:0]          rsp_turn_ff, rsp_turn_in;
   logic [SUM_W-1:0]           rsp_sum_ff, rsp_sum_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [nps_pkg::ENTRY_W-1:0] wr_data;
   logic                       rd_en;
   logic [IDX_W-1:0]           rd_addr;
   logic [nps_pkg::ENTRY_W-1:0] rd_data;

   logic [LVL_W-1:0]           rd_level;
   logic [FUEL_W-1:0]          rd_fuel;
   logic                       unserved;
   logic                       arrived;
   logic [IDX_W-1:0]           chosen;
   logic [TIME_W:0]            done_sum;
   logic [TIME_W-1:0]          pick_time;
   logic [TIME_W-1:0]          svc_time;
   logic [SUM_W:0]             sum_next;
   logic [CNT_W-1:0]           k_next;
   logic [IDX_W+JIX_W-1:0]     index_wide;

   nps_ram #(
      .WIDTH (nps_pkg::ENTRY_W),
      .DEPTH (nps_pkg::MAX_JOBS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_level   = rd_data[nps_pkg::ENTRY_W-1:FUEL_W];
   assign rd_fuel    = rd_data[FUEL_W-1:0];
   assign unserved   = !served_ff[cmp_idx_ff];
   assign arrived    = ({{TIME_W{1'b0}}, cmp_idx_ff} <= {{IDX_W{1'b0}}, clock_ff});
   assign chosen     = found_ff ? pick_ff : first_ff;
   assign done_sum   = {1'b0, clock_ff} + (TIME_W+1)'(rd_fuel);
   assign pick_time  = TIME_W'(pick_ff);
   assign svc_time   = TIME_W'(svc_ff);
   assign sum_next   = {1'b0, sum_ff} + (SUM_W+1)'(wait_ff);
   assign k_next     = k_ff + CNT_W'(1);
   assign index_wide = {{JIX_W{1'b0}}, pick_ff};

   assign wr_addr = count_ff[IDX_W-1:0];
   assign wr_data = {head.job.level, head.job.fuel};

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      served_in      = served_ff;
      clock_in       = clock_ff;
      sum_in         = sum_ff;
      k_in           = k_ff;
      scan_in        = scan_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      pick_lvl_in    = pick_lvl_ff;
      first_found_in = first_found_ff;
      first_in       = first_ff;
      svc_in         = svc_ff;
      done_in        = done_ff;
      turn_in        = turn_ff;
      wait_in        = wait_ff;
      rsp_strobe_in  = 1'b0;
      rsp_index_in   = rsp_index_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_turn_in    = rsp_turn_ff;
      rsp_sum_in     = rsp_sum_ff;
      rsp_last_in    = rsp_last_ff;
      pop            = 1'b0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = scan_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.job.keep) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (head.job.last && (head.job.keep || (count_ff != '0))) begin
                  state_in       = ST_SCAN;
                  k_in           = '0;
                  scan_in        = '0;
                  found_in       = 1'b0;
                  first_found_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // read one entry a cycle, compare it in the next cycle
            if (scan_ff < count_ff) begin
               rd_en        = 1'b1;
               scan_in      = scan_ff + CNT_W'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[IDX_W-1:0];
            end else if (!cmp_valid_ff) begin
               state_in = ST_PICK;
            end
            if (cmp_valid_ff && unserved) begin
               if (!first_found_ff) begin
                  first_found_in = 1'b1;
                  first_in       = cmp_idx_ff;
               end
               if (arrived && (!found_ff || (rd_level < pick_lvl_ff))) begin
                  found_in    = 1'b1;
                  pick_in     = cmp_idx_ff;
                  pick_lvl_in = rd_level;
               end
            end
         end
         ST_PICK: begin
            // nothing arrived yet: jump the clock to the earliest waiting job
            if (!found_ff) begin
               clock_in = TIME_W'(first_ff);
            end
            pick_in  = chosen;
            rd_en    = 1'b1;
            rd_addr  = chosen;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            svc_in   = rd_fuel;
            done_in  = done_sum[TIME_W] ? nps_pkg::CLOCK_MAX : done_sum[TIME_W-1:0];
            clock_in = done_in;
            state_in = ST_TIMES;
         end
         ST_TIMES: begin
            turn_in  = (done_ff > pick_time) ? (done_ff - pick_time) : '0;
            wait_in  = (turn_in > svc_time) ? (turn_in - svc_time) : '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            sum_in               = sum_next[SUM_W] ? nps_pkg::SUM_MAX : sum_next[SUM_W-1:0];
            served_in[pick_ff]   = 1'b1;
            rsp_strobe_in        = 1'b1;
            rsp_index_in         = index_wide[JIX_W-1:0];
            rsp_done_in          = done_ff;
            rsp_wait_in          = wait_ff;
            rsp_turn_in          = turn_ff;
            rsp_sum_in           = sum_in;
            rsp_last_in          = (k_next == count_ff);
            k_in                 = k_next;
            if (k_next == count_ff) begin
               // batch finished: clear it for the next one
               state_in  = ST_IDLE;
               count_in  = '0;
               clock_in  = '0;
               sum_in    = '0;
               served_in = '0;
            end else begin
               state_in       = ST_SCAN;
               scan_in        = '0;
               found_in       = 1'b0;
               first_found_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         served_ff     <= '0;
         clock_ff      <= '0;
         sum_ff        <= '0;
         k_ff          <= '0;
         scan_ff       <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         served_ff     <= served_in;
         clock_ff      <= clock_in;
         sum_ff        <= sum_in;
         k_ff          <= k_in;
         scan_ff       <= scan_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff     <= cmp_idx_in;
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      pick_lvl_ff    <= pick_lvl_in;
      first_found_ff <= first_found_in;
      first_ff       <= first_in;
      svc_ff         <= svc_in;
      done_ff        <= done_in;
      turn_ff        <= turn_in;
      wait_ff        <= wait_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_wait_ff    <= rsp_wait_in;
      rsp_turn_ff    <= rsp_turn_in;
      rsp_sum_ff     <= rsp_sum_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_job_index       = rsp_index_ff;
   assign rsp_completion_time = rsp_done_ff;
   assign rsp_waiting_time    = rsp_wait_ff;
   assign rsp_turnaround_time = rsp_turn_ff;
   assign rsp_total_waiting   = rsp_sum_ff;
   assign rsp_last_result     = rsp_last_ff;

endmodule

`default_nettype wire

FILE: sv/nonpreemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core
// Non-preemptive priority scheduler for one batch of up to 16 jobs.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_* with start high; the item is taken at a rising edge
//   where busy is low. Each item loads one job; its arrival time is its load
//   position. An item with req_last_job set closes the batch and schedules.
//   Items beyond 16 in a batch are dropped.
//   Results: one per served job, in service order, each shown for exactly
//   one cycle with rsp_strobe high; rsp_last_result marks the final one.
//   The receiver cannot stall; results are never held.
//   Timing: a loading item is written to the table in the same cycle that it
//   leaves the four-entry input queue. Each job of a batch is served by a
//   table scan of one entry per cycle through the job RAM read port, then
//   pick, completion, times and output. Items keep queuing while a batch
//   is served; busy rises only when the queue is full.
//   Reset: synchronous, clears the queue and the batch; no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module nonpreemptive_priority_scheduler_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [nps_pkg::FUEL_W-1:0]         req_fuel_amount,
   input  wire logic [nps_pkg::LEVEL_W-1:0]        req_urgency_level,
   input  wire logic                               req_last_job,
   output logic                                    rsp_strobe,
   output logic [nps_pkg::JOB_INDEX_W-1:0]         rsp_job_index,
   output logic [nps_pkg::TIME_W-1:0]              rsp_completion_time,
   output logic [nps_pkg::TIME_W-1:0]              rsp_waiting_time,
   output logic [nps_pkg::TIME_W-1:0]              rsp_turnaround_time,
   output logic [nps_pkg::SUM_W-1:0]               rsp_total_waiting,
   output logic                                    rsp_last_result
);

   nps_pkg::head_type head;
   logic              pop;

   nps_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_fuel_amount   (req_fuel_amount),
      .req_urgency_level (req_urgency_level),
      .req_last_job      (req_last_job),
      .head              (head),
      .pop               (pop)
   );

   nps_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .pop                 (pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_job_index       (rsp_job_index),
      .rsp_completion_time (rsp_completion_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_total_waiting   (rsp_total_waiting),
      .rsp_last_result     (rsp_last_result)
   );

endmodule

`default_nettype wire

FILE: sv/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks on the scheduler results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               busy,
   input wire logic                               rsp_strobe,
   input wire logic [nps_pkg::TIME_W-1:0]         rsp_completion_time,
   input wire logic [nps_pkg::TIME_W-1:0]         rsp_waiting_time,
   input wire logic [nps_pkg::TIME_W-1:0]         rsp_turnaround_time,
   input wire logic [nps_pkg::SUM_W-1:0]          rsp_total_waiting
);

   // every job needs a scan before its result, so strobes never abut
   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   a_wait_le_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_waiting_time <= rsp_turnaround_time))
      else $error("waiting time exceeds turnaround time");

   a_turn_le_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_turnaround_time <= rsp_completion_time))
      else $error("turnaround time exceeds completion time");

   a_total_ge_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({4'b0, rsp_waiting_time} <= rsp_total_waiting))
      else $error("running total below this job's waiting time");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("block not quiet after reset");

endmodule

bind nonpreemptive_priority_scheduler_core nps_checker u_nps_checker (.*);

`default_nettype wire

FILE: bench/tb_nonpreemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler_core
// Self-checking bench for the non-preemptive priority scheduler core. Jobs
// are loaded in batches through the start/busy port. A batch schedule is
// worked out in the bench on its closing item, and each strobed result is
// compared field by field with the oldest expected service. A directed
// opening covers zero length, level zero, ties, clock jumps, the longest
// jobs and a full table. Random batches follow under changing sender gaps.
// ----------------------------------------------------------------------------
module tb_nonpreemptive_priority_scheduler_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [nps_pkg::JOB_INDEX_W-1:0] job_index;
      logic [nps_pkg::TIME_W-1:0]      completion_time;
      logic [nps_pkg::TIME_W-1:0]      waiting_time;
      logic [nps_pkg::TIME_W-1:0]      turnaround_time;
      logic [nps_pkg::SUM_W-1:0]       total_waiting;
      logic                            last_result;
   } served_job_type;

   class batch_schedule_board;
      bit [nps_pkg::FUEL_W-1:0]  fuel_tab[nps_pkg::MAX_JOBS];
      bit [nps_pkg::LEVEL_W-1:0] level_tab[nps_pkg::MAX_JOBS];
      bit                        served[nps_pkg::MAX_JOBS];
      int unsigned               job_total;
      int unsigned               sched_clk;
      int unsigned               wait_sum;
      served_job_type            pending_services[$];
      int unsigned               error_count;

      function new();
         job_total   = 0;
         sched_clk   = 0;
         wait_sum    = 0;
         error_count = 0;
         foreach (served[i]) begin
            served[i]    = 1'b0;
            fuel_tab[i]  = '0;
            level_tab[i] = '0;
         end
      endfunction

      function int unsigned outstanding();
         return pending_services.size();
      endfunction

      // serve the whole batch in priority order, then clear it
      function void schedule_batch();
         int unsigned    n;
         int unsigned    pick;
         int unsigned    first;
         int unsigned    done;
         int unsigned    turn;
         int unsigned    wait_time;
         served_job_type r;
         n = job_total;
         for (int unsigned k = 0; k < n; k++) begin
            pick  = n;
            first = n;
            for (int unsigned j = 0; j < n; j++) begin
               if (served[j])
                  continue;
               if (first == n)
                  first = j;
               if (j <= sched_clk && (pick == n || level_tab[j] < level_tab[pick]))
                  pick = j;
            end
            // nothing has arrived yet: jump to the earliest unserved job
            if (pick == n) begin
               sched_clk = first;
               pick      = first;
            end
            served[pick] = 1'b1;
            done = sched_clk + fuel_tab[pick];
            if (done > nps_pkg::CLOCK_MAX)
               done = 32'(nps_pkg::CLOCK_MAX);
            sched_clk = done;
            turn      = (done > pick) ? done - pick : 0;
            wait_time = (turn > fuel_tab[pick]) ? turn - fuel_tab[pick] : 0;
            wait_sum  = wait_sum + wait_time;
            if (wait_sum > nps_pkg::SUM_MAX)
               wait_sum = 32'(nps_pkg::SUM_MAX);
            r.job_index       = pick[nps_pkg::JOB_INDEX_W-1:0];
            r.completion_time = done[nps_pkg::TIME_W-1:0];
            r.waiting_time    = wait_time[nps_pkg::TIME_W-1:0];
            r.turnaround_time = turn[nps_pkg::TIME_W-1:0];
            r.total_waiting   = wait_sum[nps_pkg::SUM_W-1:0];
            r.last_result     = (k + 1 == n);
            pending_services.push_back(r);
         end
         foreach (served[i])
            served[i] = 1'b0;
         job_total = 0;
         sched_clk = 0;
         wait_sum  = 0;
      endfunction

      function void note_job(bit [nps_pkg::FUEL_W-1:0] fuel,
                             bit [nps_pkg::LEVEL_W-1:0] level, bit last);
         // drop the job when the table is full
         if (job_total < nps_pkg::MAX_JOBS) begin
            fuel_tab[job_total]  = fuel;
            level_tab[job_total] = level;
            served[job_total]    = 1'b0;
            job_total++;
         end
         if (last)
            schedule_batch();
      endfunction

      function void compare(string field, longint unsigned exp, longint unsigned act);
         if (exp != act) begin
            $error("%s mismatch: expected %0d, actual %0d", field, exp, act);
            error_count++;
         end
      endfunction

      function void check_result(served_job_type got);
         served_job_type exp;
         if (pending_services.size() == 0) begin
            $error("unexpected result: job_index %0d completion_time %0d",
                   got.job_index, got.completion_time);
            error_count++;
            return;
         end
         exp = pending_services.pop_front();
         compare("job_index", exp.job_index, got.job_index);
         compare("completion_time", exp.completion_time, got.completion_time);
         compare("waiting_time", exp.waiting_time, got.waiting_time);
         compare("turnaround_time", exp.turnaround_time, got.turnaround_time);
         compare("total_waiting", exp.total_waiting, got.total_waiting);
         compare("last_result", exp.last_result, got.last_result);
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [nps_pkg::FUEL_W-1:0]      req_fuel_amount;
   logic [nps_pkg::LEVEL_W-1:0]     req_urgency_level;
   logic                            req_last_job;
   logic                            rsp_strobe;
   logic [nps_pkg::JOB_INDEX_W-1:0] rsp_job_index;
   logic [nps_pkg::TIME_W-1:0]      rsp_completion_time;
   logic [nps_pkg::TIME_W-1:0]      rsp_waiting_time;
   logic [nps_pkg::TIME_W-1:0]      rsp_turnaround_time;
   logic [nps_pkg::SUM_W-1:0]       rsp_total_waiting;
   logic                            rsp_last_result;

   batch_schedule_board board = new();

   nonpreemptive_priority_scheduler_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_fuel_amount     (req_fuel_amount),
      .req_urgency_level   (req_urgency_level),
      .req_last_job        (req_last_job),
      .rsp_strobe          (rsp_strobe),
      .rsp_job_index       (rsp_job_index),
      .rsp_completion_time (rsp_completion_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_total_waiting   (rsp_total_waiting),
      .rsp_last_result     (rsp_last_result)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin : result_monitor
      served_job_type got;
      if (!reset && rsp_strobe) begin
         got.job_index       = rsp_job_index;
         got.completion_time = rsp_completion_time;
         got.waiting_time    = rsp_waiting_time;
         got.turnaround_time = rsp_turnaround_time;
         got.total_waiting   = rsp_total_waiting;
         got.last_result     = rsp_last_result;
         board.check_result(got);
      end
   end

   // load one job, after a random gap when the sender is meant to idle
   task automatic send_job(input bit [nps_pkg::FUEL_W-1:0] fuel,
                           input bit [nps_pkg::LEVEL_W-1:0] level,
                           input bit last, input int unsigned idle_pct);
      int unsigned gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap != 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start             <= 1'b1;
      req_fuel_amount   <= fuel;
      req_urgency_level <= level;
      req_last_job      <= last;
      do @(posedge clock); while (busy);
      board.note_job(fuel, level, last);
   endtask

   task automatic send_random_batch(input int unsigned idle_pct, output int unsigned kept);
      int unsigned                size;
      bit [nps_pkg::FUEL_W-1:0]   fuel;
      bit [nps_pkg::LEVEL_W-1:0]  level;
      // mostly fitting batches, now and then one that overruns the table
      size = ($urandom_range(7) == 0)
             ? $urandom_range(nps_pkg::MAX_JOBS + 1, nps_pkg::MAX_JOBS + 4)
             : $urandom_range(1, nps_pkg::MAX_JOBS);
      kept = (size > nps_pkg::MAX_JOBS) ? nps_pkg::MAX_JOBS : size;
      for (int unsigned i = 0; i < size; i++) begin
         // short jobs leave later arrivals waiting and force clock jumps
         fuel  = ($urandom_range(1) != 0) ? nps_pkg::FUEL_W'($urandom_range(7))
                                          : nps_pkg::FUEL_W'($urandom_range(1023));
         level = nps_pkg::LEVEL_W'($urandom_range(3));
         send_job(fuel, level, i == size - 1, idle_pct);
      end
   endtask

   initial begin : stimulus
      int unsigned sender_idle_pct[3];
      int unsigned jobs_sent;
      int unsigned batch_no;
      int unsigned kept;
      sender_idle_pct   = '{0, 68, 9};
      reset             = 1'b1;
      start             = 1'b0;
      req_fuel_amount   = '0;
      req_urgency_level = '0;
      req_last_job      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single job of zero length at level zero
      send_job(10'd0, 2'd0, 1'b1, 0);
      // level zero beats level one; equal levels go to the earlier arrival
      send_job(10'd1023, 2'd3, 1'b0, 0);
      send_job(10'd3, 2'd1, 1'b0, 0);
      send_job(10'd5, 2'd0, 1'b0, 0);
      send_job(10'd7, 2'd1, 1'b1, 0);
      // zero-length jobs leave the clock behind the next arrival
      send_job(10'd0, 2'd2, 1'b0, 0);
      send_job(10'd0, 2'd1, 1'b0, 0);
      send_job(10'd2, 2'd3, 1'b1, 0);
      // full table of longest jobs; the closing item is dropped
      for (int i = 0; i < nps_pkg::MAX_JOBS; i++)
         send_job(10'd1023, i[nps_pkg::LEVEL_W-1:0], 1'b0, 0);
      send_job(10'd512, 2'd2, 1'b1, 0);

      jobs_sent = 0;
      batch_no  = 0;
      while (jobs_sent < 300) begin
         send_random_batch(sender_idle_pct[(batch_no / 5) % 3], kept);
         jobs_sent += kept;
         batch_no++;
      end
      @(negedge clock);
      start <= 1'b0;

      while (board.outstanding() != 0)
         @(posedge clock);
      // wait on so that any extra result still shows up here
      repeat (400) @(posedge clock);
      if (board.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
